@@ hdl/seng_pkg.sv @@
// ============================================================================
// seng_pkg
// Shared widths, register codes, reset values and the control store of the
// stereo envelope noise gate.
// ============================================================================
package seng_pkg;

   // Field and datapath widths
   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 24;
   localparam int LEVEL_W  = 33;
   localparam int SCALE_W  = 32;
   localparam int GAIN_W   = 33;
   localparam int ERR_W    = 34;
   localparam int MUL_W    = 34;
   localparam int PROD_W   = 2 * MUL_W;
   localparam int PC_W     = 4;
   localparam int ADDR_W   = 5;
   localparam int DATA_W   = 64;

   // Register reset values
   localparam logic [COEF_W-1:0]  ATTACK_RESET    = 24'd1677722;
   localparam logic [COEF_W-1:0]  RELEASE_RESET   = 24'd1678;
   localparam logic [LEVEL_W-1:0] THRESHOLD_RESET = 33'd429497;
   localparam logic [SCALE_W-1:0] SCALE_RESET     = 32'd655360000;

   // Level ceiling (1.0 in Q0.32) and unity gain (1.0 in Q0.16)
   localparam logic [LEVEL_W-1:0] LEVEL_MAX  = {1'b1, {(LEVEL_W-1){1'b0}}};
   localparam logic [GAIN_W-1:0]  UNITY_GAIN = 33'd65536;

   // Register indexes, taken from paddr[4:3]
   typedef enum logic [1:0] {
      CSR_ATTACK    = 2'd0,
      CSR_RELEASE   = 2'd1,
      CSR_THRESHOLD = 2'd2,
      CSR_SCALE     = 2'd3
   } csr_index_type;

   // Multiplier operand selects
   typedef enum logic [1:0] {
      A_SAMPLE = 2'd0,
      A_ERR    = 2'd1,
      A_LEVEL  = 2'd2
   } a_sel_type;

   typedef enum logic [1:0] {
      B_SAMPLE = 2'd0,
      B_COEF   = 2'd1,
      B_SCALE  = 2'd2,
      B_GAIN   = 2'd3
   } b_sel_type;

   // Sequencer branch kinds
   typedef enum logic [2:0] {
      BR_NEXT = 3'd0,
      BR_JUMP = 3'd1,
      BR_REQ  = 3'd2,
      BR_CHAN = 3'd3,
      BR_EMIT = 3'd4
   } branch_type;

   // One control word of the microprogram
   typedef struct packed {
      a_sel_type         a_sel;
      b_sel_type         b_sel;
      logic              mul_en;
      logic              err_we;
      logic              level_we;
      logic              gain_we;
      logic              out_we;
      branch_type        branch;
      logic [PC_W-1:0]   target;
   } ucode_type;

   // Step addresses
   localparam logic [PC_W-1:0] PC_IDLE    = 4'd0;
   localparam logic [PC_W-1:0] PC_CHANNEL = 4'd1;

   localparam ucode_type UC_NOP = '{
      a_sel: A_SAMPLE, b_sel: B_SAMPLE, mul_en: 1'b0, err_we: 1'b0,
      level_we: 1'b0, gain_we: 1'b0, out_we: 1'b0, branch: BR_NEXT,
      target: PC_IDLE
   };

   // Control store. Steps 1 to 8 run once per channel.
   function automatic ucode_type ucode_fetch(input logic [PC_W-1:0] pc);
      ucode_type w;
      w = UC_NOP;
      unique case (pc)
         4'd0: begin                    // wait for an input transfer
            w.branch = BR_REQ;
         end
         4'd1: begin                    // sample squared
            w.a_sel  = A_SAMPLE;
            w.b_sel  = B_SAMPLE;
            w.mul_en = 1'b1;
         end
         4'd2: begin                    // error against the level
            w.err_we = 1'b1;
         end
         4'd3: begin                    // error times attack or release
            w.a_sel  = A_ERR;
            w.b_sel  = B_COEF;
            w.mul_en = 1'b1;
         end
         4'd4: begin                    // level update with clamp
            w.level_we = 1'b1;
         end
         4'd5: begin                    // level times gate scale
            w.a_sel  = A_LEVEL;
            w.b_sel  = B_SCALE;
            w.mul_en = 1'b1;
         end
         4'd6: begin                    // gain choice
            w.gain_we = 1'b1;
         end
         4'd7: begin                    // sample times gain
            w.a_sel  = A_SAMPLE;
            w.b_sel  = B_GAIN;
            w.mul_en = 1'b1;
         end
         4'd8: begin                    // saturate, then second channel
            w.out_we = 1'b1;
            w.branch = BR_CHAN;
            w.target = PC_CHANNEL;
         end
         4'd9: begin                    // hand the frame to the output
            w.branch = BR_EMIT;
            w.target = PC_IDLE;
         end
         default: begin
            w.branch = BR_JUMP;
            w.target = PC_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

@@ hdl/stereo_envelope_noise_gate_core.sv @@
// ============================================================================
// stereo_envelope_noise_gate_core
// Envelope-following noise gate for one stereo frame per transfer.
// ============================================================================
// Usage
//   The req_ channel carries one frame of two signed 16-bit samples. The
//   rsp_ channel returns one frame of gated samples per input frame, in
//   order. Both channels transfer when valid is high and stall is low.
//   The APB port sets the attack and release coefficients, the gate
//   threshold and the gate scale; write it only while the block idles, the block itself does not enforce this.
//   A small microprogram drives one shared 34x34 multiplier and the adders;
//   each channel takes eight steps, four of them multiplications, and the
//   two channels run one after the other through the same datapath.
//   A new frame is taken only once the last one reaches the output register.
//   A finished frame waits in the output register; while the receiver
//   stalls, the sequencer holds at its last step, then returns to idle.
//   Reset clears both levels, the output valid and the sequencer, and
//   restores the register reset values.
// ============================================================================
module stereo_envelope_noise_gate_core
   import seng_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   // Input frames
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [SAMPLE_W-1:0]  req_left_sample,
   input  logic signed [SAMPLE_W-1:0]  req_right_sample,
   // Output frames
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [SAMPLE_W-1:0]  rsp_left_gated,
   output logic signed [SAMPLE_W-1:0]  rsp_right_gated,
   // Configuration
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [ADDR_W-1:0]           paddr,
   input  logic [DATA_W-1:0]           pwdata,
   output logic [DATA_W-1:0]           prdata,
   output logic                        pready
);

   // Registers and their next values
   logic [PC_W-1:0]              pc_ff, pc_in;
   logic                         ch_ff, ch_in;
   logic signed [SAMPLE_W-1:0]   left_sample_ff, left_sample_in;
   logic signed [SAMPLE_W-1:0]   right_sample_ff, right_sample_in;
   logic [LEVEL_W-1:0]           left_level_ff, left_level_in;
   logic [LEVEL_W-1:0]           right_level_ff, right_level_in;
   logic signed [ERR_W-1:0]      err_ff, err_in;
   logic signed [PROD_W-1:0]     prod_ff, prod_in;
   logic [GAIN_W-1:0]            gain_ff, gain_in;
   logic signed [SAMPLE_W-1:0]   hold_left_ff, hold_left_in;
   logic signed [SAMPLE_W-1:0]   hold_right_ff, hold_right_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0]   rsp_left_gated_ff, rsp_left_gated_in;
   logic signed [SAMPLE_W-1:0]   rsp_right_gated_ff, rsp_right_gated_in;
   logic [COEF_W-1:0]            attack_coef_ff, attack_coef_in;
   logic [COEF_W-1:0]            release_coef_ff, release_coef_in;
   logic [LEVEL_W-1:0]           gate_threshold_ff, gate_threshold_in;
   logic [SCALE_W-1:0]           gate_scale_ff, gate_scale_in;

   // Datapath signals
   ucode_type                    uc;
   logic signed [SAMPLE_W-1:0]   cur_sample;
   logic [LEVEL_W-1:0]           cur_level;
   logic                         err_pos;
   logic [COEF_W-1:0]            coef;
   logic signed [MUL_W-1:0]      mul_a;
   logic signed [MUL_W-1:0]      mul_b;
   logic [LEVEL_W-1:0]           energy;
   logic signed [ERR_W-1:0]      err_next;
   logic [ERR_W-1:0]             delta;
   logic [LEVEL_W+1:0]           level_sum;
   logic [LEVEL_W-1:0]           level_next;
   logic [GAIN_W-1:0]            gain_next;
   logic [PROD_W-32:0]           prod_upper;
   logic signed [SAMPLE_W-1:0]   sat_out;
   logic                         rsp_free;
   logic                         emit;
   logic                         csr_write;
   csr_index_type                csr_index;

   // Current control word and the channel being worked on
   always_comb begin
      uc         = ucode_fetch(pc_ff);
      cur_sample = ch_ff ? right_sample_ff : left_sample_ff;
      cur_level  = ch_ff ? right_level_ff : left_level_ff;
      err_pos    = !err_ff[ERR_W-1] && (err_ff != '0);
      coef       = err_pos ? attack_coef_ff : release_coef_ff;
   end

   // Multiplier operand selection
   always_comb begin
      unique case (uc.a_sel)
         A_SAMPLE: mul_a = MUL_W'(cur_sample);
         A_ERR:    mul_a = err_ff;
         A_LEVEL:  mul_a = $signed({1'b0, cur_level});
         default:  mul_a = '0;
      endcase
      unique case (uc.b_sel)
         B_SAMPLE: mul_b = MUL_W'(cur_sample);
         B_COEF:   mul_b = $signed({{(MUL_W-COEF_W){1'b0}}, coef});
         B_SCALE:  mul_b = $signed({{(MUL_W-SCALE_W){1'b0}}, gate_scale_ff});
         B_GAIN:   mul_b = $signed({1'b0, gain_ff});
         default:  mul_b = '0;
      endcase
   end

   // Arithmetic between multiplications
   always_comb begin
      // Energy is the square times four, so it fills Q0.32.
      energy   = {prod_ff[LEVEL_W-3:0], 2'b00};
      err_next = $signed({1'b0, energy}) - $signed({1'b0, cur_level});

      // Arithmetic shift by 24 floors; the scaled error fits in 34 bits.
      delta     = prod_ff[ERR_W+23:24];
      level_sum = {2'b00, cur_level} + {delta[ERR_W-1], delta};
      if (level_sum[LEVEL_W+1]) begin
         level_next = '0;
      end else if (level_sum[LEVEL_W] ||
                   (level_sum[LEVEL_W-1] && (level_sum[LEVEL_W-2:0] != '0))) begin
         level_next = LEVEL_MAX;
      end else begin
         level_next = level_sum[LEVEL_W-1:0];
      end

      // Proportional gain at or below the threshold, unity above it.
      gain_next = (cur_level <= gate_threshold_ff) ? prod_ff[GAIN_W+31:32] : UNITY_GAIN;

      // Shift by 16 floors; saturate when the upper bits are not all sign.
      prod_upper = prod_ff[PROD_W-1:31];
      if ((&prod_upper) || !(|prod_upper)) begin
         sat_out = prod_ff[31:16];
      end else if (prod_ff[PROD_W-1]) begin
         sat_out = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         sat_out = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
   end

   // Sequencer and datapath next state
   always_comb begin
      rsp_free = !rsp_valid_ff || !rsp_stall;
      emit     = 1'b0;

      pc_in           = pc_ff + 1'b1;
      ch_in           = ch_ff;
      left_sample_in  = left_sample_ff;
      right_sample_in = right_sample_ff;

      unique case (uc.branch)
         BR_NEXT: pc_in = pc_ff + 1'b1;
         BR_JUMP: pc_in = uc.target;
         BR_REQ: begin
            if (req_valid) begin
               left_sample_in  = req_left_sample;
               right_sample_in = req_right_sample;
               ch_in           = 1'b0;
            end else begin
               pc_in = pc_ff;
            end
         end
         BR_CHAN: begin
            if (!ch_ff) begin
               ch_in = 1'b1;
               pc_in = uc.target;
            end
         end
         BR_EMIT: begin
            if (rsp_free) begin
               emit  = 1'b1;
               pc_in = uc.target;
            end else begin
               pc_in = pc_ff;
            end
         end
         default: pc_in = PC_IDLE;
      endcase

      prod_in        = uc.mul_en ? PROD_W'(mul_a) * PROD_W'(mul_b) : prod_ff;
      err_in         = uc.err_we ? err_next : err_ff;
      gain_in        = uc.gain_we ? gain_next : gain_ff;
      left_level_in  = (uc.level_we && !ch_ff) ? level_next : left_level_ff;
      right_level_in = (uc.level_we && ch_ff) ? level_next : right_level_ff;
      hold_left_in   = (uc.out_we && !ch_ff) ? sat_out : hold_left_ff;
      hold_right_in  = (uc.out_we && ch_ff) ? sat_out : hold_right_ff;

      // Output register: loaded on emit; its valid clears once its transfer is taken.
      rsp_left_gated_in  = emit ? hold_left_ff : rsp_left_gated_ff;
      rsp_right_gated_in = emit ? hold_right_ff : rsp_right_gated_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Configuration register writes
   always_comb begin
      csr_write         = psel && penable && pwrite;
      csr_index         = csr_index_type'(paddr[ADDR_W-1:3]);
      attack_coef_in    = attack_coef_ff;
      release_coef_in   = release_coef_ff;
      gate_threshold_in = gate_threshold_ff;
      gate_scale_in     = gate_scale_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_ATTACK:    attack_coef_in    = pwdata[COEF_W-1:0];
            CSR_RELEASE:   release_coef_in   = pwdata[COEF_W-1:0];
            CSR_THRESHOLD: gate_threshold_in = pwdata[LEVEL_W-1:0];
            CSR_SCALE:     gate_scale_in     = pwdata[SCALE_W-1:0];
            default:       attack_coef_in    = attack_coef_ff;
         endcase
      end
   end

   // Configuration read-back
   always_comb begin
      unique case (csr_index_type'(paddr[ADDR_W-1:3]))
         CSR_ATTACK:    prdata = DATA_W'(attack_coef_ff);
         CSR_RELEASE:   prdata = DATA_W'(release_coef_ff);
         CSR_THRESHOLD: prdata = DATA_W'(gate_threshold_ff);
         CSR_SCALE:     prdata = DATA_W'(gate_scale_ff);
         default:       prdata = '0;
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff             <= PC_IDLE;
         ch_ff             <= 1'b0;
         left_level_ff     <= '0;
         right_level_ff    <= '0;
         rsp_valid_ff      <= 1'b0;
         attack_coef_ff    <= ATTACK_RESET;
         release_coef_ff   <= RELEASE_RESET;
         gate_threshold_ff <= THRESHOLD_RESET;
         gate_scale_ff     <= SCALE_RESET;
      end else begin
         pc_ff             <= pc_in;
         ch_ff             <= ch_in;
         left_level_ff     <= left_level_in;
         right_level_ff    <= right_level_in;
         rsp_valid_ff      <= rsp_valid_in;
         attack_coef_ff    <= attack_coef_in;
         release_coef_ff   <= release_coef_in;
         gate_threshold_ff <= gate_threshold_in;
         gate_scale_ff     <= gate_scale_in;
      end
      left_sample_ff     <= left_sample_in;
      right_sample_ff    <= right_sample_in;
      err_ff             <= err_in;
      prod_ff            <= prod_in;
      gain_ff            <= gain_in;
      hold_left_ff       <= hold_left_in;
      hold_right_ff      <= hold_right_in;
      rsp_left_gated_ff  <= rsp_left_gated_in;
      rsp_right_gated_ff <= rsp_right_gated_in;
   end

   // Port drivers
   assign req_stall       = (uc.branch != BR_REQ);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_gated  = rsp_left_gated_ff;
   assign rsp_right_gated = rsp_right_gated_ff;
   assign pready          = 1'b1;

endmodule
